// ===== rtl/core/tlct_pkg.sv =====
// ----------------------------------------------------------------------------
// tlct_pkg
// shared types, constants and functions of the telemetry line crc trailer
// ----------------------------------------------------------------------------
package tlct_pkg;

  // header characters skipped before the crc starts, by default
  localparam int HeaderSkipDefault = 2;

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // trailer characters
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  // uppercase hex digit table
  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // output phase of one request: the character, then the trailer
  typedef enum logic [2:0] {
    PH_CHAR,
    PH_STAR,
    PH_HEX3,
    PH_HEX2,
    PH_HEX1,
    PH_HEX0,
    PH_NEWLINE,
    PH_TERM
  } phase_t;

  // one accepted character with the crc after it
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] crc;
  } line_item_t;

  function automatic logic [7:0] hex_char(logic [3:0] nibble);
    return HEX_DIGITS[nibble];
  endfunction

  // eight msb-first bit steps of one byte
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/tlct_crc_update.sv =====
// ----------------------------------------------------------------------------
// tlct_crc_update
// running crc and header counter, updated on every accepted character
// ----------------------------------------------------------------------------
module tlct_crc_update
  import tlct_pkg::*;
#(
  parameter int HEADER_SKIP = HeaderSkipDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data,
  input  logic       last,
  output line_item_t item
);

  localparam logic [1:0] SKIP = HEADER_SKIP[1:0];

  logic [15:0] crc_reg;
  logic [15:0] crc_reg_next;
  logic [1:0]  header_count;
  logic [1:0]  header_count_next;
  logic        in_header;
  logic [15:0] crc_after;

  assign in_header = header_count < SKIP;
  assign crc_after = in_header ? crc_reg : crc_feed(crc_reg, data);

  assign item.data = data;
  assign item.last = last;
  assign item.crc  = crc_after;

  always_comb begin
    crc_reg_next      = crc_reg;
    header_count_next = header_count;
    if (accept) begin
      if (last) begin
        crc_reg_next      = CRC_SEED;
        header_count_next = 2'd0;
      end else if (in_header) begin
        header_count_next = header_count + 2'd1;
      end else begin
        crc_reg_next = crc_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg      <= CRC_SEED;
      header_count <= 2'd0;
    end else begin
      crc_reg      <= crc_reg_next;
      header_count <= header_count_next;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    header_count <= SKIP)
    else $error("header counter beyond skip length");

  a_line_restart : assert property (@(posedge clk) disable iff (rst)
    accept && last |=> crc_reg == CRC_SEED && header_count == 2'd0)
    else $error("crc state not restarted after line end");

  a_header_holds_crc : assert property (@(posedge clk) disable iff (rst)
    accept && in_header |=> crc_reg == CRC_SEED)
    else $error("crc moved during header");

endmodule

// ===== rtl/core/tlct_trailer_seq.sv =====
// ----------------------------------------------------------------------------
// tlct_trailer_seq
// result register and trailer sequencer
// ----------------------------------------------------------------------------
module tlct_trailer_seq
  import tlct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  line_item_t item,
  output logic       take_ready,
  output logic [7:0] frame_byte,
  output logic       frame_last,
  output logic       frame_valid,
  input  logic       frame_ready
);

  line_item_t held;
  logic       valid;
  logic       valid_next;
  phase_t     phase;
  phase_t     phase_next;
  logic       done;

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= PH_CHAR;
    end else begin
      valid <= valid_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    frame_byte = CHAR_NUL;
    frame_last = 1'b0;
    unique case (phase)
      PH_CHAR:    frame_byte = held.data;
      PH_STAR:    frame_byte = CHAR_STAR;
      PH_HEX3:    frame_byte = hex_char(held.crc[15:12]);
      PH_HEX2:    frame_byte = hex_char(held.crc[11:8]);
      PH_HEX1:    frame_byte = hex_char(held.crc[7:4]);
      PH_HEX0:    frame_byte = hex_char(held.crc[3:0]);
      PH_NEWLINE: frame_byte = CHAR_NEWLINE;
      PH_TERM: begin
        frame_byte = CHAR_NUL;
        frame_last = 1'b1;
      end
      default:    frame_byte = CHAR_NUL;
    endcase

    done       = valid && frame_ready && (phase == PH_TERM || (phase == PH_CHAR && !held.last));
    take_ready = !valid || done;

    valid_next = valid;
    phase_next = phase;
    if (accept) begin
      valid_next = 1'b1;
      phase_next = PH_CHAR;
    end else if (done) begin
      valid_next = 1'b0;
      phase_next = PH_CHAR;
    end else if (valid && frame_ready) begin
      phase_next = phase_t'(phase + 3'd1);
    end
  end

  assign frame_valid = valid;

  a_trailer_needs_end : assert property (@(posedge clk) disable iff (rst)
    valid && phase != PH_CHAR |-> held.last)
    else $error("trailer phase on a character without line end");

  a_idle_phase : assert property (@(posedge clk) disable iff (rst)
    !valid |-> phase == PH_CHAR)
    else $error("sequencer idle outside character phase");

  a_hold_while_stalled : assert property (@(posedge clk) disable iff (rst)
    valid && !frame_ready |=> valid && $stable(frame_byte) && $stable(frame_last))
    else $error("result changed while stalled");

endmodule

// ===== rtl/core/telemetry_line_crc_trailer.sv =====
// ----------------------------------------------------------------------------
// telemetry_line_crc_trailer
// passes telemetry line characters through and appends a crc-16 trailer
// ----------------------------------------------------------------------------
// output: a character is registered and appears on the output in the cycle after it is accepted
// throughput: one request per cycle while frame_ready is high; a line-end request
//   holds the output for its character, '*', four hex digits, newline and terminator
// reset: synchronous, clears the crc to ffff, the header counter to zero
//   and empties the result register
module telemetry_line_crc_trailer
  import tlct_pkg::*;
#(
  parameter int HEADER_SKIP = HeaderSkipDefault
) (
  input  logic       clk,
  input  logic       rst,
  // input characters
  input  logic       line_valid,
  output logic       line_ready,
  input  logic [7:0] line_byte,
  input  logic       line_end,
  // framed output
  output logic       frame_valid,
  input  logic       frame_ready,
  output logic [7:0] frame_byte,
  output logic       frame_last
);

  logic       accept;
  line_item_t item;

  // a request is taken whenever the result register is empty or drains now
  assign accept = line_valid && line_ready;

  // crc and header counter; the crc after this character travels with it
  tlct_crc_update #(
    .HEADER_SKIP(HEADER_SKIP)
  ) u_crc (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .data  (line_byte),
    .last  (line_end),
    .item  (item)
  );

  // result register, then trailer characters on a line end
  tlct_trailer_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .take_ready (line_ready),
    .frame_byte (frame_byte),
    .frame_last (frame_last),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready)
  );

endmodule

// ===== dv/telemetry_line_crc_trailer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// telemetry_line_crc_trailer_test
// drives telemetry lines into the trailer block with random idle and stall
// cycles, predicts every pass-through character and crc-16 trailer, and
// checks each framed byte in order against the predicted frame
// ----------------------------------------------------------------------------
module telemetry_line_crc_trailer_test;
  import tlct_pkg::*;

  localparam int HEADER_SKIP = HeaderSkipDefault;
  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 4;
  localparam int IDLE_PCT = 26;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 305;
  localparam int STEADY_FIRST = 120;
  localparam int STEADY_LAST = 200;
  localparam int DRAIN_MARK = 250;
  localparam int TAIL_CYCLES = 16;

  // header and ascii limits for line generation
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] PRINT_LOW = 8'h20;
  localparam logic [7:0] PRINT_HIGH = 8'h7E;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] LETTER_A = 8'h41;

  // --------------------------------------------------------------------------
  // frame predictor and checker
  // --------------------------------------------------------------------------
  class crc_trailer_scoreboard;
    typedef struct {
      logic [7:0] chr;
      logic       last;
    } frame_char_t;

    frame_char_t frame_q[$];
    logic [15:0] line_crc;
    int          header_seen;
    int          errors;

    function new();
      line_crc = CRC_SEED;
      header_seen = 0;
      errors = 0;
    endfunction

    // serial form of the msb-first update: feedback is crc top xor data bit
    function logic [15:0] crc_after(logic [15:0] crc, logic [7:0] chr);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ chr[i];
        c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function logic [7:0] hex_ascii(logic [3:0] nib);
      if (nib < 4'd10) begin
        return DIGIT_ZERO + 8'(nib);
      end else begin
        return LETTER_A + 8'(nib) - 8'd10;
      end
    endfunction

    function void push(logic [7:0] chr, logic last);
      frame_char_t f;
      f.chr = chr;
      f.last = last;
      frame_q.push_back(f);
    endfunction

    // one accepted request: the character itself, then the trailer on a line end
    function void note_request(logic [7:0] chr, logic line_end);
      push(chr, 1'b0);
      if (header_seen < HEADER_SKIP) begin
        header_seen++;
      end else begin
        line_crc = crc_after(line_crc, chr);
      end
      if (line_end) begin
        push(CHAR_STAR, 1'b0);
        push(hex_ascii(line_crc[15:12]), 1'b0);
        push(hex_ascii(line_crc[11:8]), 1'b0);
        push(hex_ascii(line_crc[7:4]), 1'b0);
        push(hex_ascii(line_crc[3:0]), 1'b0);
        push(CHAR_NEWLINE, 1'b0);
        push(CHAR_NUL, 1'b1);
        line_crc = CRC_SEED;
        header_seen = 0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_frame(logic [7:0] chr, logic last);
      frame_char_t f;
      if (frame_q.size() == 0) begin
        report($sformatf("unexpected frame byte %02h last %0b", chr, last));
      end else begin
        f = frame_q.pop_front();
        if (chr !== f.chr)
          report($sformatf("frame_byte expected %02h got %02h", f.chr, chr));
        if (last !== f.last)
          report($sformatf("frame_last expected %0b got %0b (byte %02h)", f.last, last, chr));
      end
    endtask

    function int pending();
      return frame_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       line_valid = 1'b0;
  logic       line_ready;
  logic [7:0] line_byte = 8'h00;
  logic       line_end = 1'b0;
  logic       frame_valid;
  logic       frame_ready = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_last;

  crc_trailer_scoreboard frame_sb = new();

  // set by the sender while neither side is allowed to idle
  bit steady = 1'b0;
  int stall_cycles = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  telemetry_line_crc_trailer #(
    .HEADER_SKIP(HEADER_SKIP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .line_valid(line_valid),
    .line_ready(line_ready),
    .line_byte(line_byte),
    .line_end(line_end),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .frame_byte(frame_byte),
    .frame_last(frame_last)
  );

  // --------------------------------------------------------------------------
  // receiving side: random back-pressure, every accepted byte is checked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && frame_valid && frame_ready) begin
      frame_sb.check_frame(frame_byte, frame_last);
    end
    frame_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog: too long without any request or expected result moving ends the run
  always @(posedge clk) begin
    if (rst || (line_valid && line_ready) ||
        (frame_valid && frame_ready && frame_sb.pending() != 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", STALL_LIMIT);
        $display("telemetry_line_crc_trailer regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sending side
  // --------------------------------------------------------------------------
  // one request; valid stays high with a steady payload until accepted
  task automatic send_char(input logic [7:0] chr, input logic last);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      line_valid <= 1'b0;
      @(posedge clk);
    end
    line_valid <= 1'b1;
    line_byte <= chr;
    line_end <= last;
    do @(posedge clk); while (!line_ready);
    frame_sb.note_request(chr, last);
  endtask

  // whole line, end mark on its final character
  task automatic send_line(input logic [7:0] chars[$]);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // random line: mostly well-formed sentences, some raw bytes, some stubs
  task automatic build_line(output logic [7:0] chars[$]);
    int kind;
    int len;
    chars = {};
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // "$$" header then printable body, possibly empty
      chars.push_back(CHAR_DOLLAR);
      chars.push_back(CHAR_DOLLAR);
      len = $urandom_range(0, 24);
      repeat (len) chars.push_back(8'($urandom_range(PRINT_LOW, PRINT_HIGH)));
    end else if (kind < 85) begin
      // full-range bytes, non-ascii and zero included
      len = $urandom_range(1, 12);
      repeat (len) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      // lines that end in or just past the header
      len = $urandom_range(1, 3);
      repeat (len) chars.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0] chars[$];
    int         sent;
    bit         drained;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines
    // line ending on its very first character, crc stays at the seed
    send_line('{8'hFF});
    // line ending on the last header character
    send_line('{CHAR_DOLLAR, 8'h00});
    // zero, all-ones and single-bit bytes past the header, final one fed too
    send_line('{CHAR_DOLLAR, CHAR_DOLLAR, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h01});
    // standard check string, trailer 29B1
    send_line('{CHAR_DOLLAR, CHAR_DOLLAR, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
                8'h36, 8'h37, 8'h38, 8'h39});

    // random lines
    sent = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      build_line(chars);
      steady = (sent >= STEADY_FIRST) && (sent < STEADY_LAST);
      if (!drained && sent >= DRAIN_MARK) begin
        // hold off until every trailer byte has come out
        drained = 1'b1;
        line_valid <= 1'b0;
        @(posedge clk);
        while (frame_sb.pending() != 0) @(posedge clk);
      end
      send_line(chars);
      sent += chars.size();
    end
    steady = 1'b0;

    // drain, then leave room for any stray output
    line_valid <= 1'b0;
    @(posedge clk);
    while (frame_sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (frame_sb.errors == 0 && frame_sb.pending() == 0) begin
      $display("telemetry_line_crc_trailer regression: pass");
    end else begin
      $display("telemetry_line_crc_trailer regression: fail");
    end
    $finish;
  end

endmodule
